>>> sv/bea_pkg.sv
// Shared types and constants for the broadcast elementwise ALU.
// Used by the channel interfaces, the divider and the top level.
package bea_pkg;

  localparam int EW     = 32;
  localparam int RANK   = 4;
  localparam int DIM_W  = 7;
  localparam int SHAPE_W = DIM_W * RANK;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;

  typedef logic [1:0]            opcode_t;
  typedef logic [5:0]            elem_index_t;
  typedef logic [31:0]           elem_value_t;
  typedef logic [1:0]            status_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [SHAPE_W-1:0]    shape_t;

  localparam opcode_t CMD_WRITE_A = 2'd0;
  localparam opcode_t CMD_WRITE_B = 2'd1;
  localparam opcode_t CMD_RUN     = 2'd2;
  localparam opcode_t CMD_NOP     = 2'd3;

  localparam cfg_index_t REG_OPERATION = 2'd0;
  localparam cfg_index_t REG_SIGNED    = 2'd1;
  localparam cfg_index_t REG_SHAPE_A   = 2'd2;
  localparam cfg_index_t REG_SHAPE_B   = 2'd3;

  localparam logic [4:0] OP_ADD = 5'd0;
  localparam logic [4:0] OP_SUB = 5'd1;
  localparam logic [4:0] OP_MUL = 5'd2;
  localparam logic [4:0] OP_DIV = 5'd3;
  localparam logic [4:0] OP_MOD = 5'd4;
  localparam logic [4:0] OP_EQ  = 5'd5;
  localparam logic [4:0] OP_GT  = 5'd6;
  localparam logic [4:0] OP_LT  = 5'd7;
  localparam logic [4:0] OP_GE  = 5'd8;
  localparam logic [4:0] OP_LE  = 5'd9;
  localparam logic [4:0] OP_AND = 5'd10;
  localparam logic [4:0] OP_OR  = 5'd11;
  localparam logic [4:0] OP_XOR = 5'd12;
  localparam logic [4:0] OP_SHL = 5'd13;
  localparam logic [4:0] OP_SHR = 5'd14;
  localparam logic [4:0] OP_MIN = 5'd15;
  localparam logic [4:0] OP_MAX = 5'd16;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_DIV_ZERO = 2'd1;
  localparam status_t ST_SHAPE    = 2'd2;

  localparam shape_t SHAPE_RESET = SHAPE_W'(2113665);

  typedef struct packed {
    logic          start;
    logic [EW-1:0] dividend;
    logic [EW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [EW-1:0] quotient;
    logic [EW-1:0] remainder;
  } div_rsp_t;

endpackage

>>> sv/bea_in_if.sv
// Request channel into the broadcast ALU: valid/ready plus one request.
// Depends on bea_pkg.
interface bea_in_if;
  import bea_pkg::*;
  logic        valid;
  logic        ready;
  opcode_t     opcode;
  elem_index_t index;
  elem_value_t value;

  modport source (output valid, opcode, index, value, input ready);
  modport sink   (input valid, opcode, index, value, output ready);
endinterface

>>> sv/bea_out_if.sv
// Result channel out of the broadcast ALU: valid/ready plus one result.
// Depends on bea_pkg.
interface bea_out_if;
  import bea_pkg::*;
  logic        valid;
  logic        ready;
  elem_index_t out_index;
  elem_value_t result_value;
  status_t     status;
  logic        last;

  modport source (output valid, out_index, result_value, status, last, input ready);
  modport sink   (input valid, out_index, result_value, status, last, output ready);
endinterface

>>> sv/bea_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> sv/bea_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on bea_pkg (request/response structs).
module bea_div (
  input  logic               clk,
  input  logic               rst,
  input  bea_pkg::div_req_t  req,
  output bea_pkg::div_rsp_t  rsp
);
  import bea_pkg::*;

  localparam int CW = $clog2(EW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [EW:0]   rem;
  logic [EW-1:0] quo;
  logic [EW-1:0] dvs;
  logic          done;
  logic [EW:0]   shifted;
  logic [EW:0]   diff;

  assign shifted = {rem[EW-1:0], quo[EW-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(EW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (!diff[EW]) begin
        rem <= diff;
      end else begin
        rem <= shifted;
      end
      quo <= {quo[EW-2:0], ~diff[EW]};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem[EW-1:0];
endmodule

>>> sv/broadcast_elementwise_alu_unit.sv
// Broadcasting elementwise integer ALU over two element RAMs.
//
// Channels: in_ch takes requests (write A, write B, run); out_ch gives
// results. cfg_we/cfg_index/cfg_data write operation, signedness and the
// two shapes; write them only while the block is idle.
// Write requests give no result. A run request checks shapes and builds
// strides, then emits one result per output position, row-major, last=1
// on the final one. A bad shape gives a single status-2 result instead.
// Each position passes through RAM read, ALU and output load; div and
// mod also wait for the bit-serial divider. The output register holds a
// result while the receiver stalls, and the walk waits behind it; in_ch
// is ready whenever no run is in progress, even with a result pending.
// Reset clears control state and config to defaults; element RAMs are
// not cleared and need no clearing pass.
// Depends on bea_pkg, bea_in_if, bea_out_if, bea_ram, bea_div.
module broadcast_elementwise_alu_unit #(
  parameter int DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  bea_in_if.sink                in_ch,
  bea_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  bea_pkg::cfg_index_t   cfg_index,
  input  bea_pkg::cfg_data_t    cfg_data
);
  import bea_pkg::*;

  localparam int RA = $clog2(DEPTH);
  localparam int AW = RA + 1;
  localparam int XW = $clog2(RANK);
  localparam int SW = $clog2(EW);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHAPE  = 3'd1;
  localparam logic [2:0] S_STRIDE = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_EXEC   = 3'd4;
  localparam logic [2:0] S_DIVW   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]   state;
  logic [4:0]   operation;
  logic         elements_signed;
  shape_t       shape_a;
  shape_t       shape_b;

  logic [XW-1:0]    ax;
  logic [DIM_W-1:0] odim  [RANK];
  logic [DIM_W-1:0] coord [RANK];
  logic [DIM_W-1:0] coord_next [RANK];
  logic [AW-1:0]    sta [RANK];
  logic [AW-1:0]    stb [RANK];
  logic [AW-1:0]    exa [RANK];
  logic [AW-1:0]    exb [RANK];
  logic [AW-1:0]    total, acc_a, acc_b, pos, ia, ib, ia_next, ib_next;
  logic             carry;

  logic [DIM_W-1:0] da, db, od;
  logic             shape_bad;
  logic [AW+DIM_W-1:0] prod_t, prod_a, prod_b;

  logic          accept, wr_ok;
  logic          ov;
  elem_index_t   o_index, res_index;
  elem_value_t   o_value, res_value;
  status_t       o_status, res_status;
  logic          o_last, res_last;
  logic          emit_go;

  logic [EW-1:0] rd_a, rd_b, alu;
  logic [2*EW-1:0] mul_full;
  logic          lt_ab, lt_ba, is_divop, neg_a, neg_b, sv_neg_a, sv_neg_b;
  logic [EW-1:0] mag_a, mag_b;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  assign accept = in_ch.valid && in_ch.ready;
  assign wr_ok  = accept && (in_ch.opcode == CMD_WRITE_A || in_ch.opcode == CMD_WRITE_B)
                  && ({1'b0, in_ch.index} < 7'(DEPTH));
  assign in_ch.ready = (state == S_IDLE);

  bea_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_a (
    .clk, .we(wr_ok && in_ch.opcode == CMD_WRITE_A), .waddr(RA'(in_ch.index)),
    .wdata(in_ch.value), .re(state == S_READ), .raddr(ia[RA-1:0]), .rdata(rd_a)
  );
  bea_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_b (
    .clk, .we(wr_ok && in_ch.opcode == CMD_WRITE_B), .waddr(RA'(in_ch.index)),
    .wdata(in_ch.value), .re(state == S_READ), .raddr(ib[RA-1:0]), .rdata(rd_b)
  );

  // shape check and stride build, one axis per cycle
  assign da = shape_a[(RANK - 1 - 32'(ax)) * DIM_W +: DIM_W];
  assign db = shape_b[(RANK - 1 - 32'(ax)) * DIM_W +: DIM_W];
  assign od = (da > db) ? da : db;
  assign shape_bad = da == '0 || db == '0 || (da != db && da != DIM_W'(1) && db != DIM_W'(1));
  assign prod_t = total * od;
  assign prod_a = acc_a * da;
  assign prod_b = acc_b * db;

  // odometer step: innermost axis first
  always_comb begin
    carry   = 1'b1;
    ia_next = ia;
    ib_next = ib;
    for (int i = RANK - 1; i >= 0; i--) begin
      coord_next[i] = coord[i];
      if (carry) begin
        if (coord[i] == odim[i] - DIM_W'(1)) begin
          coord_next[i] = '0;
          ia_next = ia_next - exa[i];
          ib_next = ib_next - exb[i];
        end else begin
          coord_next[i] = coord[i] + DIM_W'(1);
          ia_next = ia_next + sta[i];
          ib_next = ib_next + stb[i];
          carry = 1'b0;
        end
      end
    end
  end

  // elementwise ops
  assign mul_full = rd_a * rd_b;
  assign lt_ab = elements_signed ? ($signed(rd_a) < $signed(rd_b)) : (rd_a < rd_b);
  assign lt_ba = elements_signed ? ($signed(rd_b) < $signed(rd_a)) : (rd_b < rd_a);
  assign neg_a = elements_signed && rd_a[EW-1];
  assign neg_b = elements_signed && rd_b[EW-1];
  assign mag_a = neg_a ? (EW'(0) - rd_a) : rd_a;
  assign mag_b = neg_b ? (EW'(0) - rd_b) : rd_b;
  assign is_divop = (operation == OP_DIV || operation == OP_MOD);

  always_comb begin
    case (operation)
      OP_ADD: alu = rd_a + rd_b;
      OP_SUB: alu = rd_a - rd_b;
      OP_MUL: alu = mul_full[EW-1:0];
      OP_EQ:  alu = EW'(rd_a == rd_b);
      OP_GT:  alu = EW'(lt_ba);
      OP_LT:  alu = EW'(lt_ab);
      OP_GE:  alu = EW'(!lt_ab);
      OP_LE:  alu = EW'(!lt_ba);
      OP_AND: alu = rd_a & rd_b;
      OP_OR:  alu = rd_a | rd_b;
      OP_XOR: alu = rd_a ^ rd_b;
      OP_SHL: alu = (rd_b >= EW'(EW)) ? '0 : (rd_a << rd_b[SW-1:0]);
      OP_SHR: begin
        if (rd_b >= EW'(EW)) begin
          alu = '0;
        end else if (neg_a) begin
          alu = ~((~rd_a) >> rd_b[SW-1:0]);
        end else begin
          alu = rd_a >> rd_b[SW-1:0];
        end
      end
      OP_MIN: alu = lt_ba ? rd_b : rd_a;
      OP_MAX: alu = lt_ab ? rd_b : rd_a;
      default: alu = '0;
    endcase
  end

  assign div_req.start    = (state == S_EXEC) && is_divop && (rd_b != '0);
  assign div_req.dividend = mag_a;
  assign div_req.divisor  = mag_b;

  bea_div u_div (.clk, .rst, .req(div_req), .rsp(div_rsp));

  assign emit_go = (state == S_EMIT) && (!ov || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ov              <= 1'b0;
      operation       <= OP_ADD;
      elements_signed <= 1'b1;
      shape_a         <= SHAPE_RESET;
      shape_b         <= SHAPE_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OPERATION: operation       <= cfg_data[4:0];
          REG_SIGNED:    elements_signed <= cfg_data[0];
          REG_SHAPE_A:   shape_a         <= cfg_data[SHAPE_W-1:0];
          REG_SHAPE_B:   shape_b         <= cfg_data[SHAPE_W-1:0];
          default: ;
        endcase
      end
      if (emit_go) begin
        ov <= 1'b1;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE:   if (accept && in_ch.opcode == CMD_RUN) state <= S_SHAPE;
        S_SHAPE: begin
          if (shape_bad || prod_t > (AW+DIM_W)'(DEPTH)) begin
            state <= S_EMIT;
          end else if (ax == XW'(RANK - 1)) begin
            state <= S_STRIDE;
          end
        end
        S_STRIDE: if (ax == '0) state <= S_READ;
        S_READ:   state <= S_EXEC;
        S_EXEC:   state <= div_req.start ? S_DIVW : S_EMIT;
        S_DIVW:   if (div_rsp.done) state <= S_EMIT;
        S_EMIT:   if (emit_go) state <= res_last ? S_IDLE : S_READ;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ax    <= '0;
        total <= AW'(1);
      end
      S_SHAPE: begin
        if (shape_bad || prod_t > (AW+DIM_W)'(DEPTH)) begin
          res_index  <= '0;
          res_value  <= '0;
          res_status <= ST_SHAPE;
          res_last   <= 1'b1;
        end else begin
          odim[ax] <= od;
          total    <= prod_t[AW-1:0];
          // stride build walks back from the innermost axis
          ax       <= (ax == XW'(RANK - 1)) ? ax : ax + XW'(1);
          acc_a    <= AW'(1);
          acc_b    <= AW'(1);
        end
      end
      S_STRIDE: begin
        sta[ax]  <= (da == DIM_W'(1)) ? '0 : acc_a;
        stb[ax]  <= (db == DIM_W'(1)) ? '0 : acc_b;
        exa[ax]  <= (da == DIM_W'(1)) ? '0 : prod_a[AW-1:0] - acc_a;
        exb[ax]  <= (db == DIM_W'(1)) ? '0 : prod_b[AW-1:0] - acc_b;
        acc_a    <= prod_a[AW-1:0];
        acc_b    <= prod_b[AW-1:0];
        ax       <= ax - XW'(1);
        pos      <= '0;
        ia       <= '0;
        ib       <= '0;
        for (int i = 0; i < RANK; i++) begin
          coord[i] <= '0;
        end
      end
      S_READ: begin
        coord     <= coord_next;
        ia        <= ia_next;
        ib        <= ib_next;
        res_index <= 6'(pos);
        res_last  <= (pos + AW'(1) == total);
        pos       <= pos + AW'(1);
      end
      S_EXEC: begin
        res_value  <= is_divop ? '0 : alu;
        res_status <= (is_divop && rd_b == '0) ? ST_DIV_ZERO : ST_OK;
        sv_neg_a   <= neg_a;
        sv_neg_b   <= neg_b;
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          if (operation == OP_DIV) begin
            res_value <= (sv_neg_a != sv_neg_b) ? EW'(0) - div_rsp.quotient
                                                : div_rsp.quotient;
          end else begin
            res_value <= sv_neg_a ? EW'(0) - div_rsp.remainder : div_rsp.remainder;
          end
        end
      end
      default: ;
    endcase
    if (emit_go) begin
      o_index  <= res_index;
      o_value  <= res_value;
      o_status <= res_status;
      o_last   <= res_last;
    end
  end

  assign out_ch.valid        = ov;
  assign out_ch.out_index    = o_index;
  assign out_ch.result_value = o_value;
  assign out_ch.status       = o_status;
  assign out_ch.last         = o_last;

`ifndef SYNTH
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (emit_go && res_last) |=> state == S_IDLE) else $error("run did not end on last");
  a_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (ia < AW'(DEPTH) && ib < AW'(DEPTH))) else $error("address range");
  a_pos_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> pos < total) else $error("walk overran total");
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIVW) else $error("divider done outside wait");
`endif
endmodule

>>> sim/bea_checker.sv
// Result checker for the broadcast elementwise ALU: snoops requests, config writes and
// results, predicts each run and compares results field by field.
// Depends on bea_pkg, bea_in_if, bea_out_if.
module bea_checker (
  input  logic                clk,
  input  logic                rst,
  bea_in_if                   in_ch,
  bea_out_if                  out_ch,
  input  logic                cfg_we,
  input  bea_pkg::cfg_index_t cfg_index,
  input  bea_pkg::cfg_data_t  cfg_data,
  output int                  errors,
  output int                  pending
);
  import bea_pkg::*;

  typedef struct {
    elem_index_t idx;
    elem_value_t val;
    status_t     st;
    logic        last;
  } result_t;

  localparam int DEPTH = 64;

  elem_value_t mem_a [DEPTH];
  elem_value_t mem_b [DEPTH];
  logic [4:0]  alu_op;
  logic        is_signed;
  shape_t      shp_a, shp_b;
  result_t     expected_q[$];

  assign pending = expected_q.size();

  function automatic logic [6:0] dim_of(shape_t s, int k);
    return s[(RANK-1-k)*DIM_W +: DIM_W];
  endfunction

  function automatic logic below(elem_value_t a, elem_value_t b, logic sgn);
    return sgn ? ($signed(a) < $signed(b)) : (a < b);
  endfunction

  function automatic elem_value_t alu_eval(elem_value_t a, elem_value_t b, logic [4:0] op,
                                           logic sgn, output status_t st);
    logic        neg_a, neg_b;
    elem_value_t mag_a, mag_b, q, m;
    st = ST_OK;
    neg_a = sgn & a[31];
    neg_b = sgn & b[31];
    case (op)
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          st = ST_DIV_ZERO;
          return '0;
        end
        mag_a = neg_a ? -a : a;
        mag_b = neg_b ? -b : b;
        q = mag_a / mag_b;
        m = mag_a % mag_b;
        if (op == OP_DIV) return (neg_a != neg_b) ? -q : q;
        return neg_a ? -m : m;
      end
      OP_EQ:  return {31'd0, a == b};
      OP_GT:  return {31'd0, below(b, a, sgn)};
      OP_LT:  return {31'd0, below(a, b, sgn)};
      OP_GE:  return {31'd0, !below(a, b, sgn)};
      OP_LE:  return {31'd0, !below(b, a, sgn)};
      OP_AND: return a & b;
      OP_OR:  return a | b;
      OP_XOR: return a ^ b;
      OP_SHL: return (b >= EW) ? '0 : a << b[4:0];
      OP_SHR: begin
        if (b >= EW) return '0;
        return neg_a ? elem_value_t'($signed(a) >>> b[4:0]) : a >> b[4:0];
      end
      OP_MIN: return below(b, a, sgn) ? b : a;
      OP_MAX: return below(a, b, sgn) ? b : a;
      default: return '0;
    endcase
  endfunction

  task automatic predict_run();
    int      od[RANK], sta[RANK], stb[RANK];
    int      total, acc_a, acc_b, rem, ia, ib, c, da, db;
    result_t r;
    total = 1;
    for (int i = 0; i < RANK; i++) begin
      da = dim_of(shp_a, i);
      db = dim_of(shp_b, i);
      if (da == 0 || db == 0 || !(da == db || da == 1 || db == 1)) total = 0;
      od[i] = (da > db) ? da : db;
      if (total != 0) begin
        total *= od[i];
        if (total > DEPTH) total = 0;
      end
      if (total == 0) begin
        r = '{idx: '0, val: '0, st: ST_SHAPE, last: 1'b1};
        expected_q.push_back(r);
        return;
      end
    end
    acc_a = 1;
    acc_b = 1;
    for (int i = RANK-1; i >= 0; i--) begin
      da = dim_of(shp_a, i);
      db = dim_of(shp_b, i);
      sta[i] = (da == 1) ? 0 : acc_a;
      stb[i] = (db == 1) ? 0 : acc_b;
      acc_a *= da;
      acc_b *= db;
    end
    for (int lin = 0; lin < total; lin++) begin
      rem = lin;
      ia = 0;
      ib = 0;
      for (int i = RANK-1; i >= 0; i--) begin
        c = rem % od[i];
        rem /= od[i];
        ia += c * sta[i];
        ib += c * stb[i];
      end
      r.idx  = elem_index_t'(lin);
      r.val  = alu_eval(mem_a[ia], mem_b[ib], alu_op, is_signed, r.st);
      r.last = (lin == total - 1);
      expected_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    int      n_err;
    n_err = 0;
    if (rst) begin
      alu_op    <= OP_ADD;
      is_signed <= 1'b1;
      shp_a     <= SHAPE_RESET;
      shp_b     <= SHAPE_RESET;
      errors    <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OPERATION: alu_op    <= cfg_data[4:0];
          REG_SIGNED:    is_signed <= cfg_data[0];
          REG_SHAPE_A:   shp_a     <= cfg_data[SHAPE_W-1:0];
          REG_SHAPE_B:   shp_b     <= cfg_data[SHAPE_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.opcode)
          CMD_WRITE_A: mem_a[in_ch.index] = in_ch.value;
          CMD_WRITE_B: mem_b[in_ch.index] = in_ch.value;
          CMD_RUN:     predict_run();
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: out_index %0d value %h", out_ch.out_index,
                 out_ch.result_value);
          n_err++;
        end else begin
          e = expected_q.pop_front();
          if (out_ch.out_index !== e.idx) begin
            $error("out_index: expected %0d, got %0d", e.idx, out_ch.out_index);
            n_err++;
          end
          if (out_ch.result_value !== e.val) begin
            $error("result_value: expected %h, got %h", e.val, out_ch.result_value);
            n_err++;
          end
          if (out_ch.status !== e.st) begin
            $error("status: expected %0d, got %0d", e.st, out_ch.status);
            n_err++;
          end
          if (out_ch.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_ch.last);
            n_err++;
          end
        end
      end
      errors <= errors + n_err;
    end
  end
endmodule

>>> sim/broadcast_elementwise_alu_unit_tb.sv
// Top of the broadcast ALU testbench: clock, reset, request and config stimulus,
// result back-pressure and the verdict. Depends on bea_pkg, the channel interfaces,
// the block and bea_checker.
module broadcast_elementwise_alu_unit_tb;
  import bea_pkg::*;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;
  int         errors;
  int         pending;
  int         sent;
  int         burst_left;
  logic [63:0] have_a, have_b;

  bea_in_if  in_ch ();
  bea_out_if out_ch ();

  broadcast_elementwise_alu_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bea_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: almost fully stalled windows alternate with randomly stalled ones
  initial begin
    int cnt;
    int keep;
    cnt = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cnt++;
      keep = (cnt[7:6] == 2'd0) ? 1 : (cnt[8] ? 70 : 35);
      out_ch.ready <= ($urandom_range(1, 100) <= keep);
    end
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic elem_value_t pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4, 5: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_request(opcode_t op, elem_index_t idx, elem_value_t val);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.index  <= idx;
    in_ch.value  <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == CMD_WRITE_A) have_a[idx] = 1'b1;
    if (op == CMD_WRITE_B) have_b[idx] = 1'b1;
    sent++;
  endtask

  // block must be idle before config writes; writes give no result, so allow settle time
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_config(logic [4:0] op, logic sgn, shape_t sa, shape_t sb);
    drain();
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= cfg_index_t'(i);
      case (cfg_index_t'(i))
        REG_OPERATION: cfg_data <= cfg_data_t'(op);
        REG_SIGNED:    cfg_data <= cfg_data_t'(sgn);
        REG_SHAPE_A:   cfg_data <= sa;
        default:       cfg_data <= sb;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic shape_t pack_shape(int d0, int d1, int d2, int d3);
    return {7'(d0), 7'(d1), 7'(d2), 7'(d3)};
  endfunction

  // fill store entries a run will read but that were never written
  task automatic cover_reads(int na, int nb);
    for (int i = 0; i < na; i++)
      if (!have_a[i]) push_request(CMD_WRITE_A, elem_index_t'(i), pick_value());
    for (int i = 0; i < nb; i++)
      if (!have_b[i]) push_request(CMD_WRITE_B, elem_index_t'(i), pick_value());
  endtask

  task automatic random_phase();
    int         od[4], da[4], db[4];
    int         tot, na, nb, kind;
    logic [4:0] op;
    shape_t     sa, sb;
    do begin
      tot = 1;
      foreach (od[i]) begin
        od[i] = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, 5);
        tot *= od[i];
      end
    end while (tot > 64);
    na = 1;
    nb = 1;
    foreach (od[i]) begin
      da[i] = ($urandom_range(0, 2) == 0) ? 1 : od[i];
      db[i] = ($urandom_range(0, 2) == 0) ? 1 : od[i];
      na *= da[i];
      nb *= db[i];
    end
    sa = pack_shape(da[0], da[1], da[2], da[3]);
    sb = pack_shape(db[0], db[1], db[2], db[3]);
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      sa = pack_shape(1, 1, 1, 64);
      sb = ($urandom_range(0, 1) == 0) ? pack_shape(1, 1, 1, 1) : sa;
      na = 64;
      nb = (sb == sa) ? 64 : 1;
    end else if (kind == 1) begin
      sa = $urandom_range(0, 1) ? '0 : '1;
      na = 0;
      nb = 0;
    end else if (kind == 2) begin
      sa = pack_shape(1, 1, 2, 3);
      sb = pack_shape(1, 1, 3, 3);
      na = 0;
      nb = 0;
    end else if (kind == 3) begin
      sa = pack_shape(2, 1, 1, 64);
      sb = pack_shape(1, 1, 1, 1);
      na = 0;
      nb = 0;
    end else if (kind == 4) begin
      sb[$urandom_range(0, 3)*DIM_W +: DIM_W] = '0;
      na = 0;
      nb = 0;
    end
    op = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
    load_config(op, 1'($urandom_range(0, 1)), sa, sb);
    cover_reads(na, nb);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 5))
        0: push_request(CMD_WRITE_A, elem_index_t'($urandom_range(0, 63)), pick_value());
        1: push_request(CMD_WRITE_B, elem_index_t'($urandom_range(0, 63)), pick_value());
        2: push_request(CMD_NOP, elem_index_t'($urandom), $urandom);
        3: push_request(CMD_RUN, '0, '0);
        default: push_request(($urandom_range(0, 1) ? CMD_WRITE_A : CMD_WRITE_B),
                              elem_index_t'($urandom_range(0, na > nb ? na : nb)),
                              pick_value());
      endcase
    end
    push_request(CMD_RUN, elem_index_t'($urandom), $urandom);
  endtask

  initial begin
    elem_value_t a_vals[4];
    elem_value_t b_vals[4];
    a_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
    b_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'd33, 32'd5};
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_OPERATION;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= CMD_WRITE_A;
    in_ch.index <= '0;
    in_ch.value <= '0;
    sent = 0;
    burst_left = 0;
    have_a = '0;
    have_b = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: operand extremes, every operation over a 4-element vector
    for (int i = 0; i < 4; i++) begin
      push_request(CMD_WRITE_A, elem_index_t'(i), a_vals[i]);
      push_request(CMD_WRITE_B, elem_index_t'(i), b_vals[i]);
    end
    for (int op = OP_ADD; op <= OP_MAX; op++) begin
      load_config(5'(op), op[0], pack_shape(1, 1, 1, 4), pack_shape(1, 1, 1, 4));
      push_request(CMD_RUN, '0, '0);
    end

    while (sent < 460) random_phase();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> filelist.f
sv/bea_pkg.sv
sv/bea_in_if.sv
sv/bea_out_if.sv
sv/bea_ram.sv
sv/bea_div.sv
sv/broadcast_elementwise_alu_unit.sv
sim/bea_checker.sv
sim/broadcast_elementwise_alu_unit_tb.sv
